@@ sv/cpsp_pkg.sv @@
// Shared types and codes for the configuration packet stream parser.
// No dependencies; imported by every module of the block.
package cpsp_pkg;

    // result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_CLEAN_END = 3'd1;
    localparam logic [2:0] KIND_NO_SYNC   = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED = 3'd4;

    // packet header constants
    localparam logic [31:0] SYNC_PATTERN  = 32'hAA995566;
    localparam logic [23:0] SYNC_HEAD     = 24'hAA9955;
    localparam logic [7:0]  SYNC_TAIL     = 8'h66;
    localparam logic [2:0]  PKT_TYPE1     = 3'd1;
    localparam logic [2:0]  PKT_TYPE2     = 3'd2;
    localparam logic [1:0]  OP_WRITE      = 2'd2;
    localparam logic [1:0]  OP_NONE       = 2'd0;
    localparam logic [4:0]  REG_RESTART   = 5'b11110;

    // one result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] word;
        logic [2:0]  pkind;
        logic [1:0]  op;
        logic [4:0]  reg_idx;
        logic        known;
        logic [26:0] words;
        logic [31:0] pos;
        logic [7:0]  stream;
    } cpsp_result_t;

    // what one input byte causes: an optional descriptor, an optional end
    typedef struct packed {
        logic         desc_valid;
        cpsp_result_t desc;
        logic         end_valid;
        logic [2:0]   end_kind;
        logic [7:0]   end_stream;
    } cpsp_entry_t;

endpackage

@@ sv/cpsp_front.sv @@
// Front end: takes file bytes, tracks sync/header/payload state, decodes headers.
// Depends on cpsp_pkg; pushes one entry per byte that yields results.
module cpsp_front
    import cpsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        push,
    output cpsp_entry_t entry
);

    localparam logic [1:0] MODE_HUNT    = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_HALT    = 2'd3;

    logic [1:0]  mode_reg, mode_next, mode;
    logic [23:0] win_reg, win_next, win;
    logic [23:0] hdr_reg, hdr_next, hdr;
    logic [1:0]  phase_reg, phase_next, phase;
    logic [28:0] left_reg, left_next, left, left_dec;
    logic [4:0]  sel_reg_reg, sel_reg_next, sel_reg;
    logic        sel_known_reg, sel_known_next, sel_known;
    logic        sel_write_reg, sel_write_next, sel_write;
    logic [31:0] pos_reg, pos_next, pos;
    logic [31:0] hstart_reg, hstart_next, hstart;
    logic [7:0]  stream_reg, stream_next, stream;

    logic [31:0] word;
    logic [2:0]  pkind;
    logic [1:0]  d_op;
    logic [4:0]  d_reg;
    logic        d_known;
    logic [26:0] d_words;

    // a first byte restarts everything before it is parsed
    always_comb
    begin
        mode      = first_byte ? MODE_HUNT : mode_reg;
        win       = first_byte ? 24'd0 : win_reg;
        hdr       = first_byte ? 24'd0 : hdr_reg;
        phase     = first_byte ? 2'd0 : phase_reg;
        left      = first_byte ? 29'd0 : left_reg;
        sel_reg   = first_byte ? 5'd0 : sel_reg_reg;
        sel_known = first_byte ? 1'b0 : sel_known_reg;
        sel_write = first_byte ? 1'b0 : sel_write_reg;
        pos       = first_byte ? 32'd0 : pos_reg;
        hstart    = first_byte ? 32'd0 : hstart_reg;
        stream    = first_byte ? 8'd0 : stream_reg;
    end

    assign word     = {hdr, data_byte};
    assign pkind    = word[31:29];
    assign left_dec = (left != 29'd0) ? left - 29'd1 : left;

    // field decode of the assembled header
    always_comb
    begin
        if (pkind == PKT_TYPE1)
        begin
            d_op    = word[28:27];
            d_reg   = word[17:13];
            d_known = 1'b1;
            d_words = {16'd0, word[10:0]};
        end
        else
        begin
            d_op    = sel_write ? OP_WRITE : OP_NONE;
            d_known = sel_known;
            d_reg   = sel_known ? sel_reg : 5'd0;
            d_words = word[26:0];
        end
    end

    // byte-level state update
    always_comb
    begin
        mode_next      = mode;
        win_next       = win;
        hdr_next       = hdr;
        phase_next     = phase;
        left_next      = left;
        sel_reg_next   = sel_reg;
        sel_known_next = sel_known;
        sel_write_next = sel_write;
        pos_next       = pos + 32'd1;
        hstart_next    = hstart;
        stream_next    = stream;
        entry          = '0;

        unique case (mode)
            MODE_HUNT:
            begin
                win_next = {win[15:0], data_byte};
                if (win == SYNC_HEAD && data_byte == SYNC_TAIL)
                begin
                    mode_next      = MODE_HEADER;
                    phase_next     = 2'd0;
                    hdr_next       = 24'd0;
                    sel_reg_next   = 5'd0;
                    sel_known_next = 1'b0;
                    sel_write_next = 1'b0;
                end
            end
            MODE_HEADER:
            begin
                if (phase == 2'd0)
                    hstart_next = pos;
                if (phase != 2'd3)
                begin
                    hdr_next   = {hdr[15:0], data_byte};
                    phase_next = phase + 2'd1;
                end
                else
                begin
                    phase_next = 2'd0;
                    hdr_next   = 24'd0;
                    if (pkind == PKT_TYPE1 || pkind == PKT_TYPE2)
                    begin
                        if (pkind == PKT_TYPE1)
                        begin
                            sel_reg_next   = d_reg;
                            sel_known_next = 1'b1;
                            sel_write_next = (d_op == OP_WRITE);
                        end
                        entry.desc_valid   = 1'b1;
                        entry.desc.kind    = KIND_HEADER;
                        entry.desc.word    = word;
                        entry.desc.pkind   = pkind;
                        entry.desc.op      = d_op;
                        entry.desc.reg_idx = d_reg;
                        entry.desc.known   = d_known;
                        entry.desc.words   = d_words;
                        entry.desc.pos     = hstart;
                        entry.desc.stream  = stream;
                        // write with payload to the restart register: new sub-stream, hunt again
                        if (d_op == OP_WRITE && d_known && d_reg == REG_RESTART
                            && d_words != 27'd0)
                        begin
                            stream_next = stream + 8'd1;
                            mode_next   = MODE_HUNT;
                            win_next    = 24'd0;
                        end
                        else if (d_words != 27'd0)
                        begin
                            mode_next = MODE_PAYLOAD;
                            left_next = {d_words, 2'b00};
                        end
                    end
                    else if (word == SYNC_PATTERN)
                    begin
                        // sync in header position: silent new sub-stream
                        stream_next    = stream + 8'd1;
                        mode_next      = MODE_HEADER;
                        sel_reg_next   = 5'd0;
                        sel_known_next = 1'b0;
                        sel_write_next = 1'b0;
                    end
                    else
                    begin
                        entry.desc_valid  = 1'b1;
                        entry.desc.kind   = KIND_UNKNOWN;
                        entry.desc.word   = word;
                        entry.desc.pkind  = pkind;
                        entry.desc.pos    = hstart;
                        entry.desc.stream = stream;
                        mode_next         = MODE_HALT;
                    end
                end
            end
            MODE_PAYLOAD:
            begin
                left_next = left_dec;
                if (left_dec == 29'd0)
                    mode_next = MODE_HEADER;
            end
            MODE_HALT:
            begin
            end
            default:
            begin
            end
        endcase

        // end of file result
        if (last_byte && mode_next != MODE_HALT)
        begin
            entry.end_valid  = 1'b1;
            entry.end_stream = stream_next;
            unique case (mode_next)
                MODE_HUNT:    entry.end_kind = KIND_NO_SYNC;
                MODE_PAYLOAD: entry.end_kind = KIND_TRUNCATED;
                default:      entry.end_kind = KIND_CLEAN_END;
            endcase
            mode_next = MODE_HALT;
        end
    end

    assign push = accept && (entry.desc_valid || entry.end_valid);

    // state registers, advanced on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            win_reg       <= 24'd0;
            hdr_reg       <= 24'd0;
            phase_reg     <= 2'd0;
            left_reg      <= 29'd0;
            sel_reg_reg   <= 5'd0;
            sel_known_reg <= 1'b0;
            sel_write_reg <= 1'b0;
            pos_reg       <= 32'd0;
            hstart_reg    <= 32'd0;
            stream_reg    <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            win_reg       <= win_next;
            hdr_reg       <= hdr_next;
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            sel_reg_reg   <= sel_reg_next;
            sel_known_reg <= sel_known_next;
            sel_write_reg <= sel_write_next;
            pos_reg       <= pos_next;
            hstart_reg    <= hstart_next;
            stream_reg    <= stream_next;
        end
    end

    // payload countdown only runs while skipping a payload
    a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PAYLOAD) |-> (left_reg != 29'd0))
        else $error("payload mode with no bytes left");

endmodule

@@ sv/cpsp_queue.sv @@
// Short FIFO of decoded entries between front and back end.
// Depends on cpsp_pkg for the entry type.
module cpsp_queue
    import cpsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cpsp_entry_t push_entry,
    output logic        ready,
    input  logic        pop,
    output logic        head_valid,
    output cpsp_entry_t head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cpsp_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign ready      = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> ready)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ sv/cpsp_back.sv @@
// Back end: turns each queued entry into one or two result words on the output.
// Depends on cpsp_pkg; reads the head of cpsp_queue.
module cpsp_back
    import cpsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  cpsp_entry_t  head_entry,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output cpsp_result_t out_result,
    output logic         out_last
);

    logic desc_done_reg, desc_done_next;
    logic show_desc;
    logic fire;

    assign show_desc = head_entry.desc_valid && !desc_done_reg;
    assign out_valid = head_valid;
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    // pick descriptor first, end result second
    always_comb
    begin
        out_result = '0;
        if (show_desc)
        begin
            out_result = head_entry.desc;
            out_last   = !head_entry.end_valid;
        end
        else
        begin
            out_result.kind   = head_entry.end_kind;
            out_result.stream = head_entry.end_stream;
            out_last          = 1'b1;
        end
    end

    always_comb
    begin
        desc_done_next = desc_done_reg;
        if (fire)
            desc_done_next = !out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desc_done_reg <= 1'b0;
        else
            desc_done_reg <= desc_done_next;
    end

    a_done_pair: assert property (@(posedge clk) disable iff (!rst_n)
        desc_done_reg |-> (head_valid && head_entry.desc_valid && head_entry.end_valid))
        else $error("descriptor marked sent without a pending end result");

    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_entry.desc_valid || head_entry.end_valid))
        else $error("queued entry carries no result");

endmodule

@@ sv/config_packet_stream_parser.sv @@
// Top level of the configuration packet stream parser.
// Depends on cpsp_pkg, cpsp_front, cpsp_queue and cpsp_back.
//
//  channel | dir | words                 | accepted when
//  s_*     | in  | one file byte         | s_tvalid && s_tready
//  m_*     | out | one parser result     | m_tvalid && m_tready
//
// One byte is taken per cycle while s_tready is high; the state update is
// combinational. A byte with results is written into the queue and reaches m_*
// from the queue head; an end byte that also completes a header gives two words.
// s_tready drops only when the QUEUE_DEPTH-entry queue is full.
// Reset clears the parse state to hunting; no clearing pass is needed.
module config_packet_stream_parser
    import cpsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // 2 to 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] first_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] header_word, [34:32] packet_kind, [36:35] access_op,
    // [41:37] target_register, [42] register_known, [69:43] payload_words,
    // [101:70] header_position, [109:102] substream_number, [111:110] zero
    output logic [111:0] m_tdata,
    output logic [2:0]   m_tuser,   // [2:0] result_kind
    output logic         m_tlast    // run_end
);

    logic         accept;
    logic         push;
    cpsp_entry_t  push_entry;
    logic         pop;
    logic         head_valid;
    cpsp_entry_t  head_entry;
    cpsp_result_t res;

    assign accept = s_tvalid && s_tready;

    cpsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser[0]),
        .last_byte  (s_tlast),
        .push       (push),
        .entry      (push_entry)
    );

    cpsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (s_tready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    cpsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .out_last   (m_tlast)
    );

    // output word packing
    assign m_tuser = res.kind;
    assign m_tdata = {2'b00, res.stream, res.pos, res.words, res.known,
                      res.reg_idx, res.op, res.pkind, res.word};

endmodule

@@ tb/cpsp_checker.sv @@
// Scoreboard for the configuration packet stream parser: predicts the result
// words from the accepted file bytes and compares them. Depends on cpsp_pkg.
module cpsp_checker
    import cpsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,      // [7:0] data_byte
    input  logic [0:0]   s_tuser,      // [0] first_byte
    input  logic         s_tlast,      // last_byte
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] header_word, [34:32] packet_kind, [36:35] access_op,
    // [41:37] target_register, [42] register_known, [69:43] payload_words,
    // [101:70] header_position, [109:102] substream_number, [111:110] zero
    input  logic [111:0] m_tdata,
    input  logic [2:0]   m_tuser,      // [2:0] result_kind
    input  logic         m_tlast,      // run_end
    output int           errors,
    output int           outstanding
);

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_HEADER,
        MODE_PAYLOAD,
        MODE_HALT
    } parse_mode_t;

    typedef struct packed {
        cpsp_result_t res;
        logic         run_end;
    } expected_t;

    // predicted parser state
    parse_mode_t mode;
    logic [23:0] sync_window;
    logic [23:0] hdr_bytes;
    logic [1:0]  phase;
    logic [28:0] bytes_left;
    logic [4:0]  sel_reg;
    logic        sel_known;
    logic        sel_write;
    logic [31:0] byte_pos;
    logic [31:0] hdr_start;
    logic [7:0]  stream_no;

    expected_t pending_results[$];
    int error_count = 0;
    int result_count = 0;
    int pending_n = 0;

    assign errors = error_count;
    assign outstanding = pending_n;

    task automatic clear_state();
        mode = MODE_HUNT;
        sync_window = '0;
        hdr_bytes = '0;
        phase = '0;
        bytes_left = '0;
        sel_reg = '0;
        sel_known = 1'b0;
        sel_write = 1'b0;
        byte_pos = '0;
        hdr_start = '0;
        stream_no = '0;
    endtask

    // new sub-stream: header mode, selection forgotten
    task automatic start_substream();
        mode = MODE_HEADER;
        phase = '0;
        hdr_bytes = '0;
        sel_reg = '0;
        sel_known = 1'b0;
        sel_write = 1'b0;
    endtask

    function automatic cpsp_result_t make_result(input logic [2:0] kind,
                                                 input logic [31:0] word,
                                                 input logic [2:0] pkind,
                                                 input logic [1:0] op,
                                                 input logic [4:0] reg_idx,
                                                 input logic known,
                                                 input logic [26:0] words,
                                                 input logic [31:0] posn);
        cpsp_result_t r;
        r.kind = kind;
        r.word = word;
        r.pkind = pkind;
        r.op = op;
        r.reg_idx = reg_idx;
        r.known = known;
        r.words = words;
        r.pos = posn;
        r.stream = stream_no;
        return r;
    endfunction

    // decode one complete header; a sync word here gives no result
    task automatic decode_header(input logic [31:0] w, output logic emitted,
                                 output cpsp_result_t res);
        logic [2:0]  pkind;
        logic [1:0]  op;
        logic [4:0]  reg_idx;
        logic        known;
        logic [26:0] words;
        pkind = w[31:29];
        emitted = 1'b1;
        res = '0;
        if (pkind == PKT_TYPE1)
        begin
            op = w[28:27];
            reg_idx = w[17:13];
            words = {16'd0, w[10:0]};
            known = 1'b1;
            sel_reg = reg_idx;
            sel_known = 1'b1;
            sel_write = (op == OP_WRITE);
        end
        else if (pkind == PKT_TYPE2)
        begin
            words = w[26:0];
            op = sel_write ? OP_WRITE : OP_NONE;
            known = sel_known;
            reg_idx = known ? sel_reg : 5'd0;
        end
        else if (w == SYNC_PATTERN)
        begin
            stream_no++;
            start_substream();
            emitted = 1'b0;
            return;
        end
        else
        begin
            res = make_result(KIND_UNKNOWN, w, pkind, OP_NONE, 5'd0, 1'b0, 27'd0,
                              hdr_start);
            mode = MODE_HALT;
            return;
        end
        res = make_result(KIND_HEADER, w, pkind, op, reg_idx, known, words, hdr_start);
        // a write with payload to the restart register begins a new sub-stream
        if (op == OP_WRITE && known && reg_idx == REG_RESTART && words != 0)
        begin
            stream_no++;
            mode = MODE_HUNT;
            sync_window = '0;
        end
        else if (words != 0)
        begin
            mode = MODE_PAYLOAD;
            bytes_left = {words, 2'b00};
        end
    endtask

    // advance the parser by one file byte and queue the results it causes
    task automatic parse_file_byte(input logic [7:0] b, input logic first,
                                   input logic last);
        cpsp_result_t found [2];
        cpsp_result_t res;
        expected_t    e;
        logic [31:0]  here;
        logic [31:0]  word;
        logic [2:0]   end_kind;
        logic         emitted;
        int           n;
        n = 0;
        if (first)
            clear_state();
        here = byte_pos;
        byte_pos++;
        case (mode)
            MODE_HUNT:
            begin
                if (sync_window == SYNC_HEAD && b == SYNC_TAIL)
                    start_substream();
                sync_window = {sync_window[15:0], b};
            end
            MODE_HEADER:
            begin
                if (phase == 2'd0)
                    hdr_start = here;
                if (phase < 2'd3)
                begin
                    hdr_bytes = {hdr_bytes[15:0], b};
                    phase++;
                end
                else
                begin
                    word = {hdr_bytes, b};
                    phase = '0;
                    hdr_bytes = '0;
                    decode_header(word, emitted, res);
                    if (emitted)
                    begin
                        found[n] = res;
                        n++;
                    end
                end
            end
            MODE_PAYLOAD:
            begin
                if (bytes_left != 0)
                    bytes_left--;
                if (bytes_left == 0)
                    mode = MODE_HEADER;
            end
            default: ;
        endcase
        // end of file: the kind depends on where the parser stands
        if (last && mode != MODE_HALT)
        begin
            end_kind = (mode == MODE_HUNT) ? KIND_NO_SYNC :
                       (mode == MODE_PAYLOAD) ? KIND_TRUNCATED : KIND_CLEAN_END;
            found[n] = make_result(end_kind, 32'd0, 3'd0, OP_NONE, 5'd0, 1'b0, 27'd0,
                                   32'd0);
            n++;
            mode = MODE_HALT;
        end
        for (int i = 0; i < n; i++)
        begin
            e.res = found[i];
            e.run_end = (i == n - 1);
            pending_results.insert(pending_results.size(), e);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch on result %0d, %s: got %0h, expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    // compare one result word with the oldest prediction
    task automatic check_result();
        expected_t    want;
        cpsp_result_t got;
        got.kind = m_tuser;
        got.word = m_tdata[31:0];
        got.pkind = m_tdata[34:32];
        got.op = m_tdata[36:35];
        got.reg_idx = m_tdata[41:37];
        got.known = m_tdata[42];
        got.words = m_tdata[69:43];
        got.pos = m_tdata[101:70];
        got.stream = m_tdata[109:102];
        result_count++;
        if (pending_results.size() == 0)
        begin
            report("result with nothing expected", {29'd0, got.kind}, 32'd0);
            return;
        end
        want = pending_results.pop_front();
        check_field("result_kind", 32'(got.kind), 32'(want.res.kind));
        check_field("header_word", got.word, want.res.word);
        check_field("packet_kind", 32'(got.pkind), 32'(want.res.pkind));
        check_field("access_op", 32'(got.op), 32'(want.res.op));
        check_field("target_register", 32'(got.reg_idx), 32'(want.res.reg_idx));
        check_field("register_known", 32'(got.known), 32'(want.res.known));
        check_field("payload_words", 32'(got.words), 32'(want.res.words));
        check_field("header_position", got.pos, want.res.pos);
        check_field("substream_number", 32'(got.stream), 32'(want.res.stream));
        check_field("pad bits", 32'(m_tdata[111:110]), 32'd0);
        check_field("run_end", 32'(m_tlast), 32'(want.run_end));
    endtask

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            pending_results.delete();
            pending_n <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_file_byte(s_tdata, s_tuser[0], s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            pending_n <= pending_results.size();
        end
    end

endmodule

@@ tb/config_packet_stream_parser_tb.sv @@
// Testbench top for the configuration packet stream parser: feeds directed and
// random configuration files with random idling. Depends on cpsp_pkg and cpsp_checker.
module config_packet_stream_parser_tb
    import cpsp_pkg::*;
();

    localparam int RANDOM_BYTES = 1200;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 600000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // [7:0] data_byte
    logic [0:0]   s_tuser;     // [0] first_byte
    logic         s_tlast;     // last_byte
    logic         m_tvalid;
    logic         m_tready;
    // [31:0] header_word, [34:32] packet_kind, [36:35] access_op,
    // [41:37] target_register, [42] register_known, [69:43] payload_words,
    // [101:70] header_position, [109:102] substream_number, [111:110] zero
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;     // [2:0] result_kind
    logic         m_tlast;     // run_end

    int         errors;
    int         outstanding;
    int         cycle_count = 0;
    int         stall_left = 0;
    int         bytes_sent = 0;
    bit         send_gaps;
    bit         recv_stalls;
    logic [7:0] file_q[$];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    config_packet_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cpsp_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // result side: random stall bursts
    always @(posedge clk)
    begin
        if (recv_stalls && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // append one byte to the file being built
    task automatic add_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    task automatic push_word(input logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    task automatic push_random(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    // one byte word on the input channel, with an optional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_file(input bit with_first);
        int n;
        n = file_q.size();
        for (int i = 0; i < n; i++)
            send_byte(file_q[i], with_first && i == 0, i == n - 1);
        bytes_sent += n;
        file_q.delete();
    endtask

    // mostly well-formed file: sync, packets with payloads, occasional damage
    task automatic build_file();
        logic [31:0] w;
        logic [2:0]  pk;
        logic [1:0]  op;
        logic [4:0]  reg_idx;
        int          words;
        int          pick;
        int          n_pkts;
        bit          armed;
        bit          restart;
        bit          cut;
        armed = 1'b0;
        cut = 1'b0;
        push_random($urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0)
            push_word(SYNC_PATTERN);
        else
            push_word(SYNC_PATTERN ^ (32'd1 << $urandom_range(0, 31)));
        n_pkts = $urandom_range(1, 6);
        for (int k = 0; k < n_pkts && !cut; k++)
        begin
            pick = $urandom_range(0, 19);
            restart = 1'b0;
            words = 0;
            if (pick < 9)
            begin
                op = ($urandom_range(0, 1) == 1) ? OP_WRITE : 2'($urandom);
                reg_idx = ($urandom_range(0, 3) == 0) ? REG_RESTART : 5'($urandom);
                words = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, 3);
                w = {PKT_TYPE1, op, 9'($urandom), reg_idx, 2'($urandom), 11'(words)};
                armed = (op == OP_WRITE) && (reg_idx == REG_RESTART);
                restart = armed && words != 0;
                push_word(w);
            end
            else if (pick < 15)
            begin
                words = ($urandom_range(0, 15) == 0) ? int'($urandom & 32'h07FF_FFFF)
                                                     : $urandom_range(0, 3);
                restart = armed && words != 0;
                push_word({PKT_TYPE2, 27'(words)});
            end
            else if (pick < 18)
            begin
                push_word(SYNC_PATTERN);
                armed = 1'b0;
            end
            else
            begin
                // 8 wraps to type 0; every type here is undefined
                pk = 3'($urandom_range(3, 8));
                push_word({pk, 29'($urandom)});
                push_random($urandom_range(0, 2));
                cut = 1'b1;
            end
            if (restart)
            begin
                // payload is hunted for a new sync word
                push_random($urandom_range(0, 3));
                if ($urandom_range(0, 7) != 0)
                    push_word(SYNC_PATTERN);
                armed = 1'b0;
            end
            else if (words > 16)
            begin
                push_random($urandom_range(0, 8));
                cut = 1'b1;
            end
            else if (words > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_random($urandom_range(0, words * 4 - 1));
                    cut = 1'b1;
                end
                else
                    push_random(words * 4);
            end
        end
        // trailing partial header
        if (!cut && $urandom_range(0, 3) == 0)
            push_random($urandom_range(1, 3));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no first-byte mark after reset; header and clean end on one byte
        push_word(SYNC_PATTERN);
        push_word(32'h3000_0000);
        send_file(1'b0);
        // single-byte file: sync missing
        add_byte(8'hFF);
        send_file(1'b1);
        // halted parser ignores a last byte
        add_byte(8'h00);
        send_file(1'b0);
        // type 2 before any type 1, then extreme type 1 ending on its header
        push_word(SYNC_PATTERN);
        push_word(32'h4000_0001);
        push_word(32'h00FF_00FF);
        push_word(32'h3FFF_FFFF);
        send_file(1'b1);
        // sync as header, restart-register write, unknown type, halted tail
        push_word(SYNC_PATTERN);
        push_word(SYNC_PATTERN);
        push_word(32'h3003_C001);
        push_word(SYNC_PATTERN);
        push_word(32'hE000_0000);
        add_byte(8'h12);
        send_file(1'b1);
        // inherited register 31 without write, largest type 2 length, truncated
        push_word(SYNC_PATTERN);
        push_word(32'h3FFF_E000);
        push_word(32'h5FFF_FFFF);
        add_byte(8'h5A);
        send_file(1'b1);
        // trailing partial word ends cleanly
        push_word(SYNC_PATTERN);
        add_byte(8'h20);
        add_byte(8'h00);
        send_file(1'b1);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= RANDOM_BYTES - QUIET_TAIL)
            begin
                send_gaps = 1'b0;
                recv_stalls = 1'b0;
            end
            else
            begin
                send_gaps = ($urandom_range(0, 2) != 0);
                recv_stalls = ($urandom_range(0, 2) != 0);
            end
            build_file();
            send_file($urandom_range(0, 15) != 0);
        end
        s_tvalid <= 1'b0;

        // drain
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/cpsp_pkg.sv
sv/cpsp_front.sv
sv/cpsp_queue.sv
sv/cpsp_back.sv
sv/config_packet_stream_parser.sv
tb/cpsp_checker.sv
tb/config_packet_stream_parser_tb.sv
